// File: rtl/els_pkg.sv
// Shared types, codes and decode helpers for the load/store core.
package els_pkg;

  localparam logic [1:0] OP_WR  = 2'd0;
  localparam logic [1:0] OP_RD  = 2'd1;
  localparam logic [1:0] OP_EX  = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [3:0] K_NONE = 4'd0;
  localparam logic [3:0] K_LDA  = 4'd1;
  localparam logic [3:0] K_LDX  = 4'd2;
  localparam logic [3:0] K_LDY  = 4'd3;
  localparam logic [3:0] K_STA  = 4'd4;
  localparam logic [3:0] K_STX  = 4'd5;
  localparam logic [3:0] K_STY  = 4'd6;
  localparam logic [3:0] K_AND  = 4'd7;
  localparam logic [3:0] K_BIT  = 4'd8;

  localparam logic [3:0] M_IMM  = 4'd0;
  localparam logic [3:0] M_ZP   = 4'd1;
  localparam logic [3:0] M_ZPX  = 4'd2;
  localparam logic [3:0] M_ZPY  = 4'd3;
  localparam logic [3:0] M_ABS  = 4'd4;
  localparam logic [3:0] M_ABSX = 4'd5;
  localparam logic [3:0] M_ABSY = 4'd6;
  localparam logic [3:0] M_INDX = 4'd7;
  localparam logic [3:0] M_INDY = 4'd8;

  localparam logic [7:0] OPC_TAX = 8'hAA;
  localparam logic [7:0] OPC_TAY = 8'hA8;
  localparam logic [7:0] OPC_TSX = 8'hBA;
  localparam logic [7:0] OPC_TXA = 8'h8A;
  localparam logic [7:0] OPC_TXS = 8'h9A;
  localparam logic [7:0] OPC_TYA = 8'h98;
  localparam logic [7:0] OPC_PHA = 8'h48;
  localparam logic [7:0] OPC_PHP = 8'h08;
  localparam logic [7:0] OPC_PLA = 8'h68;
  localparam logic [7:0] OPC_PLP = 8'h28;

  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [15:0] PC_RESET   = 16'hFFFC;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] mode;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d.kind = K_NONE;
    d.mode = M_IMM;
    unique case (op)
      8'hA9: d = '{K_LDA, M_IMM};
      8'hA5: d = '{K_LDA, M_ZP};
      8'hB5: d = '{K_LDA, M_ZPX};
      8'hAD: d = '{K_LDA, M_ABS};
      8'hBD: d = '{K_LDA, M_ABSX};
      8'hB9: d = '{K_LDA, M_ABSY};
      8'hA1: d = '{K_LDA, M_INDX};
      8'hB1: d = '{K_LDA, M_INDY};
      8'hA2: d = '{K_LDX, M_IMM};
      8'hA6: d = '{K_LDX, M_ZP};
      8'hB6: d = '{K_LDX, M_ZPY};
      8'hAE: d = '{K_LDX, M_ABS};
      8'hBE: d = '{K_LDX, M_ABSY};
      8'hA0: d = '{K_LDY, M_IMM};
      8'hA4: d = '{K_LDY, M_ZP};
      8'hB4: d = '{K_LDY, M_ZPX};
      8'hAC: d = '{K_LDY, M_ABS};
      8'hBC: d = '{K_LDY, M_ABSX};
      8'h85: d = '{K_STA, M_ZP};
      8'h95: d = '{K_STA, M_ZPX};
      8'h8D: d = '{K_STA, M_ABS};
      8'h9D: d = '{K_STA, M_ABSX};
      8'h99: d = '{K_STA, M_ABSY};
      8'h81: d = '{K_STA, M_INDX};
      8'h91: d = '{K_STA, M_INDY};
      8'h86: d = '{K_STX, M_ZP};
      8'h96: d = '{K_STX, M_ZPY};
      8'h8E: d = '{K_STX, M_ABS};
      8'h84: d = '{K_STY, M_ZP};
      8'h94: d = '{K_STY, M_ZPX};
      8'h8C: d = '{K_STY, M_ABS};
      8'h29: d = '{K_AND, M_IMM};
      8'h25: d = '{K_AND, M_ZP};
      8'h35: d = '{K_AND, M_ZPX};
      8'h2D: d = '{K_AND, M_ABS};
      8'h3D: d = '{K_AND, M_ABSX};
      8'h39: d = '{K_AND, M_ABSY};
      8'h21: d = '{K_AND, M_INDX};
      8'h31: d = '{K_AND, M_INDY};
      8'h24: d = '{K_BIT, M_ZP};
      8'h2C: d = '{K_BIT, M_ABS};
      default: d = '{K_NONE, M_IMM};
    endcase
    return d;
  endfunction

  // Z and N from a value, C and V kept.
  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    return {v[7], p[6:2], (v == 8'h00), p[0]};
  endfunction

endpackage

// File: rtl/eight_bit_cpu_load_store_core_unit.sv
// Top level: 6502-subset load/store core with a single-port byte memory.
// Instructions advance one sequencer step per memory access through the single RAM port.
// Throughput: one item at a time; busy drops as the result strobe rises.
// Reset: synchronous rst; afterwards the whole memory is cleared one byte per cycle
//   with busy high. The receiver cannot stall results.
module eight_bit_cpu_load_store_core_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] mem_address,
  input  logic [7:0]  mem_data,
  output logic        done,
  output logic [7:0]  read_byte,
  output logic [7:0]  acc_value,
  output logic [7:0]  x_value,
  output logic [7:0]  y_value,
  output logic [7:0]  sp_value,
  output logic [15:0] pc_value,
  output logic [7:0]  flags_value,
  output logic [2:0]  step_cycles,
  output logic [47:0] cycle_total,
  output logic        unknown_opcode
);

  localparam int MemDepth = 1 << ADDR_BITS;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_OPC   = 4'd3;
  localparam logic [3:0] S_OPND1 = 4'd4;
  localparam logic [3:0] S_OPND2 = 4'd5;
  localparam logic [3:0] S_PTRLO = 4'd6;
  localparam logic [3:0] S_PTRHI = 4'd7;
  localparam logic [3:0] S_DATA  = 4'd8;
  localparam logic [3:0] S_PULL  = 4'd9;

  // architectural and sequencer registers
  logic [3:0]           state, state_next;
  logic [ADDR_BITS-1:0] clr_addr, clr_addr_next;
  logic [7:0]           acc, acc_next;
  logic [7:0]           xr, xr_next;
  logic [7:0]           yr, yr_next;
  logic [7:0]           sp, sp_next;
  logic [15:0]          pc, pc_next;
  logic [7:0]           flags, flags_next;
  logic [47:0]          total, total_next;
  logic [7:0]           opcode, opcode_next;
  logic [3:0]           kind, kind_next;
  logic [3:0]           mode, mode_next;
  logic [7:0]           lo, lo_next;
  logic [7:0]           zp, zp_next;
  logic [2:0]           step, step_next;
  logic                 done_next;
  logic [7:0]           read_byte_next;
  logic [2:0]           step_cycles_next;
  logic                 unknown_next;

  // RAM port and shared adder
  logic                 ram_we;
  logic [15:0]          ram_a16;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;
  logic [15:0]          add_a, add_b, add_sum;
  logic                 add_cross;

  // step helpers
  logic                 do_access, do_exec, do_finish, unk;
  logic [15:0]          ea;
  logic [7:0]           exec_val, rb_val, stv;
  logic                 is_st;
  logic [7:0]           idx;
  els_pkg::dec_t        dec;

  els_ram #(.WIDTH(8), .DEPTH(MemDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_a16[ADDR_BITS-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  els_add u_add (
    .a          (add_a),
    .b          (add_b),
    .sum        (add_sum),
    .page_cross (add_cross)
  );

  assign is_st = (kind == els_pkg::K_STA) || (kind == els_pkg::K_STX) ||
                 (kind == els_pkg::K_STY);
  assign stv   = (kind == els_pkg::K_STA) ? acc : ((kind == els_pkg::K_STX) ? xr : yr);
  // index register for the current mode
  assign idx   = ((mode == els_pkg::M_ZPY) || (mode == els_pkg::M_ABSY) ||
                  (mode == els_pkg::M_INDY)) ? yr : xr;
  assign dec   = els_pkg::decode(ram_rdata);

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    acc_next         = acc;
    xr_next          = xr;
    yr_next          = yr;
    sp_next          = sp;
    pc_next          = pc;
    flags_next       = flags;
    total_next       = total;
    opcode_next      = opcode;
    kind_next        = kind;
    mode_next        = mode;
    lo_next          = lo;
    zp_next          = zp;
    step_next        = step;
    done_next        = 1'b0;
    read_byte_next   = read_byte;
    step_cycles_next = step_cycles;
    unknown_next     = unknown_opcode;
    ram_we           = 1'b0;
    ram_a16          = pc;
    ram_wdata        = 8'h00;
    add_a            = pc;
    add_b            = 16'd1;
    do_access        = 1'b0;
    do_exec          = 1'b0;
    do_finish        = 1'b0;
    unk              = 1'b0;
    ea               = 16'h0000;
    exec_val         = ram_rdata;
    rb_val           = 8'h00;

    unique case (state)
      S_CLR: begin
        ram_we        = 1'b1;
        ram_a16       = 16'(clr_addr);
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        step_next = 3'd0;
        if (start) begin
          unique case (operation)
            els_pkg::OP_WR: begin
              ram_we    = 1'b1;
              ram_a16   = mem_address;
              ram_wdata = mem_data;
              do_finish = 1'b1;
            end
            els_pkg::OP_RD: begin
              ram_a16    = mem_address;
              state_next = S_RD;
            end
            els_pkg::OP_EX: begin
              pc_next    = add_sum;
              state_next = S_OPC;
            end
            default: do_finish = 1'b1;
          endcase
        end
      end
      S_RD: begin
        rb_val    = ram_rdata;
        do_finish = 1'b1;
      end
      S_OPC: begin
        opcode_next = ram_rdata;
        kind_next   = dec.kind;
        mode_next   = dec.mode;
        step_next   = 3'd1;
        if (dec.kind != els_pkg::K_NONE) begin
          pc_next    = add_sum;
          state_next = S_OPND1;
        end else begin
          unique case (ram_rdata)
            els_pkg::OPC_TAX: begin
              xr_next = acc; flags_next = els_pkg::set_zn(flags, acc);
              step_next = 3'd2; do_finish = 1'b1;
            end
            els_pkg::OPC_TAY: begin
              yr_next = acc; flags_next = els_pkg::set_zn(flags, acc);
              step_next = 3'd2; do_finish = 1'b1;
            end
            els_pkg::OPC_TSX: begin
              xr_next = sp; flags_next = els_pkg::set_zn(flags, sp);
              step_next = 3'd2; do_finish = 1'b1;
            end
            els_pkg::OPC_TXA: begin
              acc_next = xr; flags_next = els_pkg::set_zn(flags, xr);
              step_next = 3'd2; do_finish = 1'b1;
            end
            els_pkg::OPC_TXS: begin
              sp_next = xr; step_next = 3'd2; do_finish = 1'b1;
            end
            els_pkg::OPC_TYA: begin
              acc_next = yr; flags_next = els_pkg::set_zn(flags, yr);
              step_next = 3'd2; do_finish = 1'b1;
            end
            els_pkg::OPC_PHA, els_pkg::OPC_PHP: begin
              ram_we    = 1'b1;
              ram_a16   = {els_pkg::STACK_PAGE, sp};
              ram_wdata = (ram_rdata == els_pkg::OPC_PHA) ? acc : flags;
              sp_next   = sp - 8'd1;
              step_next = 3'd3;
              do_finish = 1'b1;
            end
            els_pkg::OPC_PLA, els_pkg::OPC_PLP: begin
              add_a      = {8'h00, sp};
              sp_next    = add_sum[7:0];
              ram_a16    = {els_pkg::STACK_PAGE, add_sum[7:0]};
              step_next  = 3'd4;
              state_next = S_PULL;
            end
            default: begin
              unk       = 1'b1;
              do_finish = 1'b1;
            end
          endcase
        end
      end
      S_PULL: begin
        if (opcode == els_pkg::OPC_PLA) begin
          acc_next   = ram_rdata;
          flags_next = els_pkg::set_zn(flags, ram_rdata);
        end else begin
          flags_next = ram_rdata;
        end
        do_finish = 1'b1;
      end
      S_OPND1: begin
        step_next = step + 3'd1;
        unique case (mode)
          els_pkg::M_IMM: do_exec = 1'b1;
          els_pkg::M_ZP: begin
            ea = {8'h00, ram_rdata}; do_access = 1'b1;
          end
          els_pkg::M_ZPX, els_pkg::M_ZPY: begin
            add_a     = {8'h00, ram_rdata};
            add_b     = {8'h00, idx};
            ea        = {8'h00, add_sum[7:0]};
            step_next = step + 3'd2;
            do_access = 1'b1;
          end
          els_pkg::M_ABS, els_pkg::M_ABSX, els_pkg::M_ABSY: begin
            lo_next    = ram_rdata;
            pc_next    = add_sum;
            state_next = S_OPND2;
          end
          els_pkg::M_INDX: begin
            add_a      = {8'h00, ram_rdata};
            add_b      = {8'h00, xr};
            zp_next    = add_sum[7:0];
            ram_a16    = {8'h00, add_sum[7:0]};
            step_next  = step + 3'd2;
            state_next = S_PTRLO;
          end
          default: begin
            zp_next    = ram_rdata;
            ram_a16    = {8'h00, ram_rdata};
            state_next = S_PTRLO;
          end
        endcase
      end
      S_OPND2: begin
        step_next = step + 3'd1;
        add_a     = {ram_rdata, lo};
        add_b     = {8'h00, idx};
        if (mode == els_pkg::M_ABS) begin
          ea = {ram_rdata, lo};
        end else begin
          ea = add_sum;
          if (is_st || add_cross) begin
            step_next = step + 3'd2;
          end
        end
        do_access = 1'b1;
      end
      S_PTRLO: begin
        lo_next    = ram_rdata;
        add_a      = {8'h00, zp};
        ram_a16    = {8'h00, add_sum[7:0]};
        state_next = S_PTRHI;
      end
      S_PTRHI: begin
        step_next = step + 3'd2;
        add_a     = {ram_rdata, lo};
        add_b     = {8'h00, yr};
        if (mode == els_pkg::M_INDX) begin
          ea = {ram_rdata, lo};
        end else begin
          ea = add_sum;
          if (is_st || add_cross) begin
            step_next = step + 3'd3;
          end
        end
        do_access = 1'b1;
      end
      S_DATA: begin
        step_next = step + 3'd1;
        do_exec   = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase

    // operand access: stores write now, reads come back in S_DATA
    if (do_access) begin
      ram_a16 = ea;
      if (is_st) begin
        ram_we    = 1'b1;
        ram_wdata = stv;
        step_next = step_next + 3'd1;
        do_finish = 1'b1;
      end else begin
        state_next = S_DATA;
      end
    end

    // apply a fetched operand
    if (do_exec) begin
      unique case (kind)
        els_pkg::K_LDA: begin
          acc_next = exec_val; flags_next = els_pkg::set_zn(flags, exec_val);
        end
        els_pkg::K_LDX: begin
          xr_next = exec_val; flags_next = els_pkg::set_zn(flags, exec_val);
        end
        els_pkg::K_LDY: begin
          yr_next = exec_val; flags_next = els_pkg::set_zn(flags, exec_val);
        end
        els_pkg::K_AND: begin
          acc_next   = acc & exec_val;
          flags_next = els_pkg::set_zn(flags, acc & exec_val);
        end
        els_pkg::K_BIT: begin
          flags_next = {exec_val[7:6], flags[5:2], ((acc & exec_val) == 8'h00), flags[0]};
        end
        default: ;
      endcase
      do_finish = 1'b1;
    end

    // result strobe next cycle; running total absorbs this item's cycles
    if (do_finish) begin
      done_next        = 1'b1;
      state_next       = S_IDLE;
      total_next       = total + 48'(step_next);
      step_cycles_next = step_next;
      read_byte_next   = rb_val;
      unknown_next     = unk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      clr_addr       <= '0;
      acc            <= 8'h00;
      xr             <= 8'h00;
      yr             <= 8'h00;
      sp             <= 8'hFF;
      pc             <= els_pkg::PC_RESET;
      flags          <= 8'h00;
      total          <= 48'h0;
      step           <= 3'd0;
      done           <= 1'b0;
      read_byte      <= 8'h00;
      step_cycles    <= 3'd0;
      unknown_opcode <= 1'b0;
    end else begin
      state          <= state_next;
      clr_addr       <= clr_addr_next;
      acc            <= acc_next;
      xr             <= xr_next;
      yr             <= yr_next;
      sp             <= sp_next;
      pc             <= pc_next;
      flags          <= flags_next;
      total          <= total_next;
      step           <= step_next;
      done           <= done_next;
      read_byte      <= read_byte_next;
      step_cycles    <= step_cycles_next;
      unknown_opcode <= unknown_next;
    end
  end

  always_ff @(posedge clk) begin
    opcode <= opcode_next;
    kind   <= kind_next;
    mode   <= mode_next;
    lo     <= lo_next;
    zp     <= zp_next;
  end

  assign busy        = (state != S_IDLE);
  assign acc_value   = acc;
  assign x_value     = xr;
  assign y_value     = yr;
  assign sp_value    = sp;
  assign pc_value    = pc;
  assign flags_value = flags;
  assign cycle_total = total;

`ifndef SYNTHESIS
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> busy) else $error("clear pass not busy");
  a_unk_one: assert property (@(posedge clk) disable iff (rst)
    (done && unknown_opcode) |-> (step_cycles == 3'd1 && read_byte == 8'h00))
    else $error("unknown opcode result malformed");
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    (done && step_cycles == 3'd0) |-> !unknown_opcode)
    else $error("memory op flagged unknown");
  a_total: assert property (@(posedge clk) disable iff (rst)
    done |-> (total == $past(total) + 48'(step_cycles)))
    else $error("cycle total mismatch");
`endif

endmodule

// File: rtl/els_ram.sv
// Generic single-port RAM with registered read.
module els_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/els_add.sv
// Shared 16-bit address adder with page-cross detect.
module els_add (
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [15:0] sum,
  output logic        page_cross
);

  assign sum        = a + b;
  assign page_cross = (sum[15:8] != a[15:8]);

endmodule
